@@ hdl/assert_macros.svh @@
// assertion macros used by the held note table controller
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold whenever not in reset
`define CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ hdl/hnt_pkg.sv @@
// types and constants for the held note table
// no dependencies
package hnt_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_CLEAR  = 3'd2;
  localparam logic [2:0] REQ_GET    = 3'd3;
  localparam logic [2:0] REQ_FIND   = 3'd4;
  localparam logic [2:0] REQ_SORT   = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] pitch;
    logic [3:0] chan;
    logic       bypass_flag;
    logic       latched_flag;
    logic [7:0] slot;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] found_slot;
    logic [6:0] out_pitch;
    logic [3:0] out_chan;
    logic       out_bypass;
    logic       out_latched;
    logic [4:0] note_count;
    logic [4:0] held_count;
  } rsp_t;

  typedef struct packed {
    logic [6:0] pitch;
    logic [3:0] chan;
    logic       bypass;
    logic       latched;
  } note_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_SHIFT, ST_APPEND, ST_GET, ST_SORT_LOAD,
    ST_SORT_CMP, ST_SORT_PUT, ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic ptr_clear;
    logic ptr_inc;
    logic ptr_from_key;  // j = k for insertion sort
    logic ptr_dec;
    logic key_inc;
    logic key_load;      // cur = entries[k]
    logic shift_down;    // entries[j] = entries[j+1]
    logic shift_up;      // entries[j] = entries[j-1]
    logic put_cur;       // entries[j] = cur
    logic append;
    logic drop_count;
    logic add_count;
    logic clear_counts;
    logic set_hit;       // record j as match
    logic get_read;
    logic set_ok;
    logic strobe;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       ptr_at_end;   // j >= count
    logic       match;        // entries[j].pitch == pitch, pitch valid
    logic       full;
    logic       slot_ok;
    logic       key_end;      // k >= count
    logic       ptr_zero;
    logic       prev_greater; // entries[j-1].pitch > cur.pitch
  } sts_t;

endpackage

@@ hdl/hnt_ctrl.sv @@
// controller state machine for the held note table
// depends on hnt_pkg, assert_macros.svh
`include "assert_macros.svh"
module hnt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  hnt_pkg::sts_t sts,
  output hnt_pkg::cmd_t cmd
);
  import hnt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          cmd.ptr_clear = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        case (sts.req_type)
          REQ_ADD, REQ_REMOVE, REQ_FIND: begin
            if (sts.req_type == REQ_ADD && sts.full) begin
              state_next = ST_DONE;
            end else if (sts.ptr_at_end) begin
              if (sts.req_type == REQ_ADD) state_next = ST_APPEND;
              else state_next = ST_DONE;
            end else if (sts.match) begin
              cmd.set_hit = 1'b1;
              if (sts.req_type == REQ_FIND) begin
                cmd.set_ok = 1'b1;
                state_next = ST_DONE;
              end else begin
                cmd.drop_count = 1'b1;
                state_next = ST_SHIFT;
              end
            end else begin
              cmd.ptr_inc = 1'b1;
            end
          end
          REQ_CLEAR: begin
            cmd.clear_counts = 1'b1;
            cmd.set_ok = 1'b1;
            state_next = ST_DONE;
          end
          REQ_GET: state_next = ST_GET;
          REQ_SORT: begin
            cmd.key_inc = 1'b1;
            state_next = ST_SORT_LOAD;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_SHIFT: begin
        // count already dropped, so end is j >= new count
        if (sts.ptr_at_end) begin
          if (sts.req_type == REQ_ADD) state_next = ST_APPEND;
          else begin
            cmd.set_ok = 1'b1;
            state_next = ST_DONE;
          end
        end else begin
          cmd.shift_down = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        cmd.add_count = 1'b1;
        cmd.set_ok = 1'b1;
        state_next = ST_DONE;
      end
      ST_GET: begin
        cmd.get_read = 1'b1;
        state_next = ST_DONE;
      end
      ST_SORT_LOAD: begin
        if (sts.key_end) begin
          cmd.set_ok = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.key_load = 1'b1;
          cmd.ptr_from_key = 1'b1;
          state_next = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        if (!sts.ptr_zero && sts.prev_greater) begin
          cmd.shift_up = 1'b1;
          cmd.ptr_dec = 1'b1;
        end else begin
          state_next = ST_SORT_PUT;
        end
      end
      ST_SORT_PUT: begin
        cmd.put_cur = 1'b1;
        cmd.key_inc = 1'b1;
        state_next = ST_SORT_LOAD;
      end
      ST_DONE: begin
        cmd.strobe = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CHK(a_strobe_done, !cmd.strobe || state == ST_DONE, "strobe outside done")
  `CHK_NEXT(a_start_busy, state == ST_IDLE && start, busy, "start not taken")
  `CHK_NEXT(a_done_idle, state == ST_DONE, state == ST_IDLE, "done did not return to idle")

endmodule

@@ hdl/hnt_dp.sv @@
// datapath of the held note table: entry registers, counts, pointers
// depends on hnt_pkg
module hnt_dp (
  input  logic          clk,
  input  logic          rst,
  input  hnt_pkg::req_t req,
  input  hnt_pkg::cmd_t cmd,
  output hnt_pkg::sts_t sts,
  output logic          strobe,
  output hnt_pkg::rsp_t rsp
);
  import hnt_pkg::*;

  note_t            entries [TABLE_SIZE];
  req_t             r;
  logic [CNT_W-1:0] entry_total, held_total;
  logic [CNT_W-1:0] j, k;
  logic [IDX_W-1:0] hit_idx;
  note_t            cur;
  logic             ok;
  note_t            get_note;

  logic [IDX_W-1:0] ji, jp, jm, ki, ti;

  assign ji = j[IDX_W-1:0];
  assign ki = k[IDX_W-1:0];
  assign ti = entry_total[IDX_W-1:0];
  assign jp = ji + 1'b1;
  assign jm = ji - 1'b1;

  always_comb begin
    sts.req_type     = r.req_type;
    sts.ptr_at_end   = (j >= entry_total);
    sts.match        = (r.pitch != 7'd0) && (entries[ji].pitch == r.pitch);
    sts.full         = (entry_total >= CNT_W'(TABLE_SIZE));
    sts.slot_ok      = ({1'b0, r.slot} < 9'(entry_total));
    sts.key_end      = (k >= entry_total);
    sts.ptr_zero     = (j == '0);
    sts.prev_greater = (entries[jm].pitch > cur.pitch);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) r <= req;
    if (cmd.key_load) cur <= entries[ki];
    if (cmd.set_hit) hit_idx <= ji;
    if (cmd.shift_down) entries[ji] <= entries[jp];
    if (cmd.shift_up) entries[ji] <= entries[jm];
    if (cmd.put_cur) entries[ji] <= cur;
    if (cmd.append) entries[ti] <= '{r.pitch, r.chan, r.bypass_flag, r.latched_flag};
    if (cmd.get_read) get_note <= entries[r.slot[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_total <= '0;
      held_total <= '0;
      j <= '0;
      k <= '0;
      ok <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.strobe;
      if (cmd.ptr_clear) j <= '0;
      else if (cmd.ptr_inc) j <= j + 1'b1;
      else if (cmd.ptr_dec) j <= j - 1'b1;
      else if (cmd.ptr_from_key) j <= k;
      if (cmd.load_req) begin
        k <= '0;
        ok <= 1'b0;
      end else if (cmd.key_inc) k <= k + 1'b1;
      if (cmd.set_ok) ok <= 1'b1;
      if (cmd.get_read) ok <= sts.slot_ok;
      if (cmd.clear_counts) begin
        entry_total <= '0;
        held_total <= '0;
      end
      if (cmd.drop_count) begin
        entry_total <= entry_total - 1'b1;
        if (!entries[ji].latched && held_total != '0) held_total <= held_total - 1'b1;
      end
      if (cmd.add_count) begin
        entry_total <= entry_total + 1'b1;
        if (!r.latched_flag) held_total <= held_total + 1'b1;
      end
    end
  end

  // get path reads only with ok, find reports the hit index
  always_comb begin
    rsp = '0;
    rsp.ok = ok;
    rsp.note_count = 5'(entry_total);
    rsp.held_count = 5'(held_total);
    if (ok && r.req_type == REQ_FIND) rsp.found_slot = 4'(hit_idx);
    if (ok && r.req_type == REQ_GET) begin
      rsp.out_pitch = get_note.pitch;
      rsp.out_chan = get_note.chan;
      rsp.out_bypass = get_note.bypass;
      rsp.out_latched = get_note.latched;
    end
  end

endmodule

@@ hdl/held_note_table.sv @@
// held note table: one request per start, one result per request; the
// result cannot be stalled. Clear and get do not walk the table; add,
// remove and find search the held entries (a match is shifted out for
// add and remove, then add appends), and sort runs an insertion sort, so
// their time grows with the number of entries held.
// busy drops in the result cycle, so the next request may follow directly.
// depends on hnt_pkg, hnt_ctrl, hnt_dp
module held_note_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  hnt_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output hnt_pkg::rsp_t rsp
);
  import hnt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hnt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  hnt_dp u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .sts(sts), .strobe(done), .rsp(rsp)
  );

endmodule

@@ sim/tb_held_note_table.sv @@
// testbench for the held note table: random and directed requests, results
// checked against a behavioral table model held in a small scoreboard class
// depends on hnt_pkg and held_note_table
`timescale 1ns / 1ps

module tb_held_note_table;
  import hnt_pkg::*;

  localparam int N_RANDOM = 1900;

  // behavioral model of the note table plus a queue of pending results
  class note_scoreboard;
    note_t  notes[TABLE_SIZE];
    int     n_notes;
    int     n_held;
    rsp_t   pending[$];
    int     errors;

    function new();
      n_notes = 0;
      n_held = 0;
      errors = 0;
    endfunction

    function int locate(logic [6:0] p);
      int k;
      if (p == 0) return -1;
      for (k = 0; k < n_notes; k++)
        if (notes[k].pitch == p) return k;
      return -1;
    endfunction

    function bit drop(logic [6:0] p);
      int at;
      int k;
      note_t gone;
      at = locate(p);
      if (at < 0) return 0;
      gone = notes[at];
      for (k = at; k + 1 < n_notes; k++) notes[k] = notes[k + 1];
      n_notes--;
      if (!gone.latched && n_held > 0) n_held--;
      return 1;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int at;
      int k;
      int m;
      note_t cur;
      e = '0;
      case (r.req_type)
        REQ_ADD: begin
          if (n_notes < TABLE_SIZE) begin
            void'(drop(r.pitch));
            notes[n_notes] = '{r.pitch, r.chan, r.bypass_flag, r.latched_flag};
            n_notes++;
            if (!r.latched_flag) n_held++;
            e.ok = 1;
          end
        end
        REQ_REMOVE: e.ok = drop(r.pitch);
        REQ_CLEAR: begin
          n_notes = 0;
          n_held = 0;
          e.ok = 1;
        end
        REQ_GET: begin
          if (r.slot < n_notes) begin
            e.ok = 1;
            e.out_pitch = notes[r.slot].pitch;
            e.out_chan = notes[r.slot].chan;
            e.out_bypass = notes[r.slot].bypass;
            e.out_latched = notes[r.slot].latched;
          end
        end
        REQ_FIND: begin
          at = locate(r.pitch);
          if (at >= 0) begin
            e.ok = 1;
            e.found_slot = at[3:0];
          end
        end
        REQ_SORT: begin
          // stable insertion sort by pitch
          for (k = 1; k < n_notes; k++) begin
            cur = notes[k];
            m = k;
            while (m > 0 && notes[m - 1].pitch > cur.pitch) begin
              notes[m] = notes[m - 1];
              m--;
            end
            notes[m] = cur;
          end
          e.ok = 1;
        end
        default: ;
      endcase
      e.note_count = n_notes[4:0];
      e.held_count = n_held[4:0];
      pending.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected ok=%0d slot=%0d p=%0d ch=%0d b=%0d l=%0d n=%0d h=%0d",
                   e.ok, e.found_slot, e.out_pitch, e.out_chan, e.out_bypass,
                   e.out_latched, e.note_count, e.held_count,
                   "\n          actual   ok=%0d slot=%0d p=%0d ch=%0d b=%0d l=%0d n=%0d h=%0d",
                   got.ok, got.found_slot, got.out_pitch, got.out_chan, got.out_bypass,
                   got.out_latched, got.note_count, got.held_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;

  note_scoreboard board;
  logic [6:0] pitch_pool[8];

  held_note_table dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(rsp);
  end

  // called at a falling edge; busy is stable there
  task automatic send(req_t r);
    int gap;
    // mostly short gaps, a few long, some none
    case ($urandom_range(0, 9))
      0, 1, 2: gap = 0;
      9: gap = $urandom_range(10, 60);
      default: gap = $urandom_range(1, 4);
    endcase
    while (busy) @(negedge clk);
    repeat (gap) @(negedge clk);
    req <= r;
    start <= 1'b1;
    // busy is low, so the transfer happens at this edge
    @(posedge clk);
    board.note_request(r);
    @(negedge clk);
    start <= 1'b0;
    req <= req_t'($urandom);
  endtask

  function automatic req_t make_req(logic [2:0] t, int p, int s);
    req_t r;
    r = req_t'({$urandom, $urandom});
    r.req_type = t;
    r.pitch = 7'(p);
    r.slot = 8'(s);
    return r;
  endfunction

  function automatic logic [6:0] pick_pitch();
    if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 127));
    return pitch_pool[$urandom_range(0, 7)];
  endfunction

  initial begin
    int i;
    int k;
    int w;
    req_t r;
    board = new();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    for (k = 0; k < 8; k++) pitch_pool[k] = 7'($urandom_range(0, 127));
    pitch_pool[0] = 7'd127;
    pitch_pool[1] = 7'd0;
    pitch_pool[2] = 7'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty ops, fill past full with edge pitches, duplicates, sort
    send(make_req(REQ_GET, 0, 0));
    send(make_req(REQ_FIND, 5, 0));
    send(make_req(REQ_REMOVE, 5, 0));
    send(make_req(3'd6, 5, 0));
    send(make_req(3'd7, 5, 0));
    for (k = 0; k < 17; k++) begin
      r = make_req(REQ_ADD, (k == 0) ? 127 : (k == 1) ? 0 : 100 - 5 * k, 0);
      r.latched_flag = k[0];
      send(r);
    end
    send(make_req(REQ_ADD, 127, 0));
    send(make_req(REQ_GET, 15, 15));
    send(make_req(REQ_GET, 0, 255));
    send(make_req(REQ_FIND, 0, 0));
    send(make_req(REQ_FIND, 127, 0));
    send(make_req(REQ_SORT, 0, 0));
    send(make_req(REQ_REMOVE, 127, 0));
    send(make_req(REQ_ADD, 0, 0));
    send(make_req(REQ_ADD, 127, 0));
    send(make_req(REQ_CLEAR, 0, 0));

    for (i = 0; i < N_RANDOM; i++) begin
      w = $urandom_range(0, 99);
      if (w < 40) r = make_req(REQ_ADD, pick_pitch(), 0);
      else if (w < 55) r = make_req(REQ_REMOVE, pick_pitch(), 0);
      else if (w < 57) r = make_req(REQ_CLEAR, 0, 0);
      else if (w < 75)
        r = make_req(REQ_GET, 0, ($urandom_range(0, 9) == 0) ?
                     $urandom_range(0, 255) : $urandom_range(0, 17));
      else if (w < 88) r = make_req(REQ_FIND, pick_pitch(), 0);
      else if (w < 97) r = make_req(REQ_SORT, 0, 0);
      else r = make_req(3'($urandom_range(6, 7)), pick_pitch(), 0);
      if ($urandom_range(0, 199) == 0)
        for (k = 0; k < 8; k++) pitch_pool[k] = 7'($urandom_range(0, 127));
      send(r);
    end

    w = 0;
    while (board.pending.size() != 0 && w < 2000) begin
      @(posedge clk);
      w++;
    end
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/hnt_pkg.sv
hdl/hnt_ctrl.sv
hdl/hnt_dp.sv
hdl/held_note_table.sv
sim/tb_held_note_table.sv
